// ===== src/http_body_length_scanner_defines.svh =====
// ----------------------------------------------------------------------------
// HTTP body length scanner assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_BODY_LENGTH_SCANNER_DEFINES_SVH
`define HTTP_BODY_LENGTH_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HBLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbls checker: same-cycle property failed");

// Next-cycle implication, disabled during reset
`define HBLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbls checker: next-cycle property failed");

`endif

// ===== src/hbls_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP body length scanner package
// Shared constants, status codes and the classified item type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbls_pkg;

  // Default width of the length value and the body counter
  localparam int unsigned DEF_LENGTH_BITS = 32;

  // Depth of the queue between the classifier and the scanner
  localparam int unsigned QUEUE_DEPTH = 2;

  // Header name pattern "Content-Length:"
  localparam int unsigned LEN_PAT_LEN = 15;
  localparam logic [7:0] LEN_PAT [LEN_PAT_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
  };

  // Blank line pattern CR LF CR LF
  localparam int unsigned BLANK_PAT_LEN = 4;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;

  // Result status codes
  localparam logic [2:0] ST_HEADER   = 3'd0;
  localparam logic [2:0] ST_BODY     = 3'd1;
  localparam logic [2:0] ST_LAST     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;
  localparam logic [2:0] ST_ENDHDR   = 3'd6;

  // Classified input item
  typedef struct packed {
    logic                   eor;
    logic [7:0]             data;
    logic                   is_cr;
    logic                   is_lf;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [LEN_PAT_LEN-1:0] len_hit;
  } hbls_item_t;

endpackage

// ===== src/hbls_front.sv =====
// ----------------------------------------------------------------------------
// HTTP body length scanner classifier
// Tags each incoming item with the byte tests that the scanner needs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbls_front
  import hbls_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  logic       end_of_response_i,
  output hbls_item_t item_o
);

  // Classify the byte and compare it against every header name character
  always_comb begin
    item_o.eor      = end_of_response_i;
    item_o.data     = data_byte_i;
    item_o.is_cr    = (data_byte_i == CHAR_CR);
    item_o.is_lf    = (data_byte_i == CHAR_LF);
    item_o.is_digit = (data_byte_i >= CHAR_0) && (data_byte_i <= CHAR_9);
    item_o.digit    = data_byte_i[3:0];
    for (int i = 0; i < LEN_PAT_LEN; i++) begin
      item_o.len_hit[i] = (data_byte_i == LEN_PAT[i]);
    end
  end

endmodule

// ===== src/hbls_queue.sv =====
// ----------------------------------------------------------------------------
// HTTP body length scanner item queue
// Small FIFO that decouples the classifier from the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbls_queue
  import hbls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hbls_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output hbls_item_t item_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  hbls_item_t    mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/hbls_back.sv =====
// ----------------------------------------------------------------------------
// HTTP body length scanner engine
// Scans header, parses length, counts body; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbls_back
  import hbls_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  hbls_item_t q_item_i,
  output logic       q_pop_o,
  output logic [7:0] body_byte_o,
  output logic [2:0] status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  localparam logic [2:0] PH_FIND_LEN   = 3'd0;
  localparam logic [2:0] PH_SKIP       = 3'd1;
  localparam logic [2:0] PH_DIGITS     = 3'd2;
  localparam logic [2:0] PH_WAIT_CR    = 3'd3;
  localparam logic [2:0] PH_FIND_BLANK = 3'd4;
  localparam logic [2:0] PH_BODY       = 3'd5;
  localparam logic [2:0] PH_DONE       = 3'd6;
  localparam logic [2:0] PH_FAILED     = 3'd7;

  localparam logic [3:0] LEN_PAT_CNT   = 4'(LEN_PAT_LEN);
  localparam logic [3:0] BLANK_PAT_CNT = 4'(BLANK_PAT_LEN);
  localparam int unsigned AW = LENGTH_BITS + 4;

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             match_q, match_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic                   out_valid_q;
  logic [7:0]             body_byte_q, body_byte_d;
  logic [2:0]             status_q, status_d;

  logic                   take;
  logic [3:0]             mm_len, m1_len;
  logic [3:0]             mm_blank, m1_blank;
  logic                   hit_len, hit_blank;
  logic [AW-1:0]          len_ext, acc;
  logic [LENGTH_BITS-1:0] cnt_inc;

  // Pop when the output register is free or being drained
  assign take    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = take;

  // Header name match step, restart on mismatch
  always_comb begin
    mm_len  = (match_q >= LEN_PAT_CNT) ? 4'd0 : match_q;
    hit_len = q_item_i.len_hit[mm_len];
    m1_len  = hit_len ? mm_len + 4'd1 : {3'd0, q_item_i.len_hit[0]};
  end

  // Blank line match step: even positions want CR, odd ones LF
  always_comb begin
    mm_blank  = (match_q >= BLANK_PAT_CNT) ? 4'd0 : match_q;
    hit_blank = mm_blank[0] ? q_item_i.is_lf : q_item_i.is_cr;
    m1_blank  = hit_blank ? mm_blank + 4'd1 : {3'd0, q_item_i.is_cr};
  end

  // Decimal accumulate as x*8 + x*2 + digit, saturate on carry out
  always_comb begin
    len_ext = {4'd0, len_q};
    acc     = (len_ext << 3) + (len_ext << 1) + {{(AW-4){1'b0}}, q_item_i.digit};
    cnt_inc = cnt_q + 1'b1;
  end

  // Scanner state update and result
  always_comb begin
    phase_d     = phase_q;
    match_d     = match_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    status_d    = ST_HEADER;
    body_byte_d = 8'd0;
    if (q_item_i.eor) begin
      if (phase_q == PH_BODY) begin
        status_d = ST_TRUNC;
      end else if (phase_q >= PH_DONE) begin
        status_d = ST_IGNORED;
      end else begin
        status_d = ST_ENDHDR;
      end
      phase_d = PH_FIND_LEN;
      match_d = '0;
      len_d   = '0;
      cnt_d   = '0;
    end else begin
      unique case (phase_q)
        PH_FIND_LEN: begin
          if (m1_len == LEN_PAT_CNT) begin
            match_d = '0;
            phase_d = PH_SKIP;
          end else begin
            match_d = m1_len;
          end
        end
        PH_SKIP: begin
          len_d   = '0;
          phase_d = PH_DIGITS;
        end
        PH_DIGITS, PH_WAIT_CR: begin
          if (q_item_i.is_cr) begin
            match_d = 4'd1;
            phase_d = PH_FIND_BLANK;
          end else if (phase_q == PH_DIGITS && q_item_i.is_digit) begin
            if (acc[AW-1:LENGTH_BITS] != 4'd0) begin
              len_d = '1;
            end else begin
              len_d = acc[LENGTH_BITS-1:0];
            end
          end else begin
            phase_d = PH_WAIT_CR;
          end
        end
        PH_FIND_BLANK: begin
          if (m1_blank == BLANK_PAT_CNT) begin
            match_d = '0;
            cnt_d   = '0;
            phase_d = (len_q == '0) ? PH_DONE : PH_BODY;
          end else begin
            match_d = m1_blank;
          end
        end
        PH_BODY: begin
          if (cnt_q >= len_q) begin
            status_d = ST_OVERFLOW;
            phase_d  = PH_FAILED;
          end else begin
            cnt_d       = cnt_inc;
            body_byte_d = q_item_i.data;
            if (cnt_inc == len_q) begin
              status_d = ST_LAST;
              phase_d  = PH_DONE;
            end else begin
              status_d = ST_BODY;
            end
          end
        end
        default: begin
          status_d = ST_IGNORED;
        end
      endcase
    end
  end

  // Hold state and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIND_LEN;
      match_q     <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        match_q <= match_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      body_byte_q <= body_byte_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign body_byte_o = body_byte_q;
  assign status_o    = status_q;

endmodule

// ===== src/http_body_length_scanner.sv =====
// An accepted item passes through the queue and then the output register.
// Throughput: one item per cycle while the output is not stalled.
// A two-entry queue separates the classifier from the scanner; the output
// register holds a result while the next item is taken.
// Reset (rst_ni low, asynchronous) empties the queue and output and returns
// the scanner to the header search with zero length and count.
// ----------------------------------------------------------------------------
// HTTP body length scanner
// Finds Content-Length, waits for the blank line and delimits the body.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_body_length_scanner
  import hbls_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_response_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] body_byte_o,
  output logic [2:0] status_o
);

  hbls_item_t cls_item;
  hbls_item_t q_item;
  logic       q_full, q_valid, q_pop;

  // Classify the incoming item
  hbls_front u_front (
    .data_byte_i       (data_byte_i),
    .end_of_response_i (end_of_response_i),
    .item_o            (cls_item)
  );

  // Queue classified items
  hbls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (cls_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  assign in_stall_o = q_full;

  // Scan and deliver results
  hbls_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .body_byte_o (body_byte_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== src/hbls_checker.sv =====
// ----------------------------------------------------------------------------
// HTTP body length scanner port checker
// Watches the top-level ports for result coding and output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_body_length_scanner_defines.svh"

module hbls_checker
  import hbls_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] body_byte_o,
  input logic [2:0] status_o
);

  // No result carries the unused status code
  `HBLS_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, status_o <= ST_ENDHDR)

  // Only body and last-body results carry a byte
  `HBLS_ASSERT_NOW(a_byte_zero, clk_i, rst_ni,
    out_valid_o && status_o != ST_BODY && status_o != ST_LAST, body_byte_o == 8'd0)

  // A stalled result holds
  `HBLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(body_byte_o))

endmodule

bind http_body_length_scanner hbls_checker u_hbls_checker (.*);
